>>> hdl/vfld_pkg.sv
// Shared types, constants and helpers for the video frame loss detector.
`timescale 1ns / 1ps

package vfld_pkg;

  // Slot storage
  localparam int NumSlots = 16;
  localparam int SlotW    = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // Loss limit register
  localparam int          LimitW         = 6;
  localparam logic [5:0]  MaxMissedReset = 6'd30;

  // Saturating divider: quotient bits 6..0, bit 6 means "too far"
  localparam int QuoW = LimitW + 1;
  localparam int RemW = 32 + LimitW;
  localparam int CntW = $clog2(QuoW);

  // Input beat
  typedef struct packed {
    logic [3:0]  slot;
    logic        fresh_slot;
    logic [15:0] sequence_req;
    logic [31:0] timestamp;
    logic        completes_frame;
  } pkt_in_t;

  // Result beat
  typedef struct packed {
    logic [5:0]  conceal_count;
    logic        frame_dropped;
    logic [5:0]  missed_added;
    logic [31:0] dropped_total;
    logic [31:0] missed_total;
  } pkt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic calc;
    logic div_step;
    logic write;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } status_t;

  // Slot field to storage index, wrapping modulo the slot count
  function automatic logic [SlotW-1:0] slot_index(input logic [3:0] v);
    logic [SlotW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v == 4'(i)) r = SlotW'(i % NumSlots);
    end
    return r;
  endfunction

endpackage

>>> hdl/video_frame_loss_detector_unit.sv
// Top level of the video frame loss detector.
//
//  channel | direction | beat
//  --------+-----------+------------------------------------------------
//  in      | input     | pkt_in_t: slot, fresh, sequence, timestamp, done
//  out     | output    | pkt_out_t: conceal, dropped, missed, two totals
//  cfg     | input     | max_missed_steps, 6 bits, always ready
//
// A packet passes the accept, slot read and write-back steps when no divide
// is needed, with divide steps between when the timestamp skip is divided by
// the learned step: the shared divider resolves one quotient bit per cycle.
// Reset clears all slot state at once; the limit resets to 30.
// A stalled result holds the write-back step; the next packet is taken
// while a finished result still waits.
`timescale 1ns / 1ps

module video_frame_loss_detector_unit
  import vfld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pkt_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pkt_out_t          out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  vfld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vfld_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> hdl/vfld_ctrl.sv
// Sequencing state machine for the video frame loss detector.
`timescale 1ns / 1ps

module vfld_ctrl
  import vfld_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCalc  = 4'b0010,
    StDiv   = 4'b0100,
    StWrite = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StCalc;
        end
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d    = status_i.need_div ? StDiv : StWrite;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = StWrite;
      end
      StWrite: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.write = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/vfld_datapath.sv
// Slot state, delta and saturating divider, result register.
`timescale 1ns / 1ps

module vfld_datapath
  import vfld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkt_in_t           in_data_i,
  input  logic              cfg_valid_i,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output pkt_out_t          out_data_o,
  input  cmd_t              cmd_i,
  output status_t           status_o
);

  // Per-slot state
  logic        seq_seen_q   [NumSlots];
  logic [15:0] prev_seq_q   [NumSlots];
  logic        stamp_seen_q [NumSlots];
  logic [31:0] stamp_q      [NumSlots];
  logic        done_q       [NumSlots];
  logic [31:0] step_q       [NumSlots];
  logic [31:0] dcnt_q       [NumSlots];
  logic [31:0] mcnt_q       [NumSlots];

  logic [LimitW-1:0] limit_q;
  pkt_in_t           in_q;
  logic [SlotW-1:0]  idx_q;

  // Working copy of the slot, taken in the calc step
  logic        contig_q, changed_q, sseen_q, done_r_q, need_div_q;
  logic [31:0] stamp_r_q, step_r_q, dcnt_r_q, mcnt_r_q;
  logic [RemW-1:0] rem_q, dvs_q;
  logic [QuoW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;

  pkt_out_t out_q;
  logic     out_valid_q;

  // Slot read, with a fresh stream seen as cleared state
  logic        rd_seq_seen, rd_stamp_seen, rd_done;
  logic [15:0] rd_prev;
  logic [31:0] rd_stamp, rd_step, rd_dcnt, rd_mcnt, delta;
  logic        contig, changed, need_div;

  always_comb begin
    rd_seq_seen   = seq_seen_q[idx_q]   & ~in_q.fresh_slot;
    rd_stamp_seen = stamp_seen_q[idx_q] & ~in_q.fresh_slot;
    rd_done       = done_q[idx_q]       & ~in_q.fresh_slot;
    rd_prev       = in_q.fresh_slot ? '0 : prev_seq_q[idx_q];
    rd_stamp      = in_q.fresh_slot ? '0 : stamp_q[idx_q];
    rd_step       = in_q.fresh_slot ? '0 : step_q[idx_q];
    rd_dcnt       = in_q.fresh_slot ? '0 : dcnt_q[idx_q];
    rd_mcnt       = in_q.fresh_slot ? '0 : mcnt_q[idx_q];
    contig        = rd_seq_seen && ((rd_prev + 16'd1) == in_q.sequence_req);
    changed       = rd_stamp_seen && (in_q.timestamp != rd_stamp);
    delta         = in_q.timestamp - rd_stamp;
    need_div      = changed && !contig && (rd_step != '0);
  end

  // Divider step: one quotient bit per cycle
  logic div_ge;
  assign div_ge = (rem_q >= dvs_q);

  // Result and write-back values
  logic              new_frame, dropped, hit;
  logic [LimitW-1:0] quo_lo, missed;
  logic [31:0]       dtot, mtot, step_w;

  always_comb begin
    quo_lo    = quo_q[LimitW-1:0];
    new_frame = !sseen_q || changed_q;
    dropped   = changed_q && !done_r_q;
    hit       = need_div_q && !quo_q[QuoW-1] && (quo_lo > 6'd1) && (quo_lo <= limit_q);
    missed    = hit ? (quo_lo - 6'd1) : '0;
    dtot      = dcnt_r_q + 32'(dropped);
    mtot      = mcnt_r_q + 32'(missed);
    // delta is untouched in rem_q when the sequence was contiguous
    step_w    = (changed_q && contig_q) ? rem_q[31:0] : step_r_q;
  end

  // Config, input capture, working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxMissedReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q  <= in_data_i;
      idx_q <= slot_index(in_data_i.slot);
    end
    if (cmd_i.calc) begin
      contig_q   <= contig;
      changed_q  <= changed;
      need_div_q <= need_div;
      sseen_q    <= rd_stamp_seen;
      done_r_q   <= rd_done;
      stamp_r_q  <= rd_stamp;
      step_r_q   <= rd_step;
      dcnt_r_q   <= rd_dcnt;
      mcnt_r_q   <= rd_mcnt;
      rem_q      <= RemW'(delta);
      dvs_q      <= {rd_step, {LimitW{1'b0}}};
      quo_q      <= '0;
      cnt_q      <= CntW'(QuoW - 1);
    end else if (cmd_i.div_step) begin
      if (div_ge) rem_q <= rem_q - dvs_q;
      quo_q <= {quo_q[QuoW-2:0], div_ge};
      dvs_q <= dvs_q >> 1;
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Slot state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        seq_seen_q[i]   <= 1'b0;
        prev_seq_q[i]   <= '0;
        stamp_seen_q[i] <= 1'b0;
        stamp_q[i]      <= '0;
        done_q[i]       <= 1'b0;
        step_q[i]       <= '0;
        dcnt_q[i]       <= '0;
        mcnt_q[i]       <= '0;
      end
    end else if (cmd_i.write) begin
      seq_seen_q[idx_q]   <= 1'b1;
      prev_seq_q[idx_q]   <= in_q.sequence_req;
      stamp_seen_q[idx_q] <= 1'b1;
      stamp_q[idx_q]      <= new_frame ? in_q.timestamp : stamp_r_q;
      done_q[idx_q]       <= in_q.completes_frame || (!new_frame && done_r_q);
      step_q[idx_q]       <= step_w;
      dcnt_q[idx_q]       <= dtot;
      mcnt_q[idx_q]       <= mtot;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_q.conceal_count <= 6'(dropped) + missed;
      out_q.frame_dropped <= dropped;
      out_q.missed_added  <= missed;
      out_q.dropped_total <= dtot;
      out_q.missed_total  <= mtot;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.need_div = need_div;
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

endmodule
